### rtl/chacha20_keystream_block_assert.svh
// Assertion macros for the keystream block RTL.
// Needs a clock named clk and an active-low reset named rst_n in the using module.
`ifndef CHACHA20_KEYSTREAM_BLOCK_ASSERT_SVH
`define CHACHA20_KEYSTREAM_BLOCK_ASSERT_SVH

`ifndef SYNTHESIS

// expr holds at every edge outside reset
`define CC20KS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// ante at one edge implies cons at the next
`define CC20KS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CC20KS_ASSERT_ALWAYS(label, expr, msg)
`define CC20KS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/cc20ks_pkg.sv
// Shared types and constants for the keystream block.
// No dependencies.
`default_nettype none

package cc20ks_pkg;

  localparam int WORD_W     = 32;
  localparam int NUM_WORDS  = 16;
  localparam int IDX_W      = 4;
  localparam int ROUNDS_DEF = 20;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_ADDR_W-1:0] REG_KEY_01   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_23   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_45   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_67   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_NONCE_01 = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_NONCE_2  = 3'd5;

  localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;

  typedef struct packed {
    word_t  ctr;
    state_t st;
  } cell_data_t;

  localparam word_t SIGMA_0 = 32'h61707865;
  localparam word_t SIGMA_1 = 32'h3320646e;
  localparam word_t SIGMA_2 = 32'h79622d32;
  localparam word_t SIGMA_3 = 32'h6b206574;

endpackage

`default_nettype wire

### rtl/chacha20_keystream_block.sv
// ChaCha20 keystream block: top level with configuration registers, round chain
// and output stage. Depends on cc20ks_pkg, cc20ks_round_cell and cc20ks_emit.
//
// Usage:
//   cfg_*  : write key and nonce registers by index while the block is idle.
//   in_*   : one word per block, the 32-bit block counter in in_tdata.
//   out_*  : 16 keystream words per block, in order; out_tdata holds the
//            word index and the keystream word, out_tlast marks word 15.
// Flow: the counter passes a chain of ROUNDS round cells, each running its
//   round and then holding the result until the next cell or the output stage
//   takes it.
// Throughput: one output word per cycle while the receiver is ready; the first
//   cell takes a new counter only after handing on its last one, and the
//   chain holds up to ROUNDS blocks in flight, so the input keeps taking
//   counters while earlier blocks still run or wait at the output.
// Reset clears the configuration registers and empties the chain and the
//   output stage.
// When the receiver stalls, the output word holds, finished blocks queue in
//   the chain cells and in_tready drops once the first cell is occupied.
`default_nettype none

module chacha20_keystream_block #(
  parameter int ROUNDS = cc20ks_pkg::ROUNDS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [cc20ks_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [cc20ks_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [cc20ks_pkg::IN_TDATA_W-1:0]    in_tdata,   // [31:0] block_counter
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [cc20ks_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [3:0] word_index, [35:4] keystream_word
  output logic                                 out_tlast
);

  import cc20ks_pkg::*;

  logic [CFG_DATA_W-1:0] key01_r;
  logic [CFG_DATA_W-1:0] key23_r;
  logic [CFG_DATA_W-1:0] key45_r;
  logic [CFG_DATA_W-1:0] key67_r;
  logic [CFG_DATA_W-1:0] nonce01_r;
  word_t                 nonce2_r;

  function automatic state_t make_init(word_t ctr, logic [CFG_DATA_W-1:0] k01,
                                       logic [CFG_DATA_W-1:0] k23,
                                       logic [CFG_DATA_W-1:0] k45,
                                       logic [CFG_DATA_W-1:0] k67,
                                       logic [CFG_DATA_W-1:0] n01, word_t n2);
    state_t s;
    s[0]  = SIGMA_0;
    s[1]  = SIGMA_1;
    s[2]  = SIGMA_2;
    s[3]  = SIGMA_3;
    s[4]  = k01[31:0];
    s[5]  = k01[63:32];
    s[6]  = k23[31:0];
    s[7]  = k23[63:32];
    s[8]  = k45[31:0];
    s[9]  = k45[63:32];
    s[10] = k67[31:0];
    s[11] = k67[63:32];
    s[12] = ctr;
    s[13] = n01[31:0];
    s[14] = n01[63:32];
    s[15] = n2;
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r   <= '0;
      key23_r   <= '0;
      key45_r   <= '0;
      key67_r   <= '0;
      nonce01_r <= '0;
      nonce2_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KEY_01:   key01_r   <= cfg_wdata;
        REG_KEY_23:   key23_r   <= cfg_wdata;
        REG_KEY_45:   key45_r   <= cfg_wdata;
        REG_KEY_67:   key67_r   <= cfg_wdata;
        REG_NONCE_01: nonce01_r <= cfg_wdata;
        REG_NONCE_2:  nonce2_r  <= cfg_wdata[WORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [ROUNDS:0] link_valid;
  logic [ROUNDS:0] link_ready;
  cell_data_t      link_data [ROUNDS+1];

  assign link_valid[0]     = in_tvalid;
  assign in_tready         = link_ready[0];
  assign link_data[0].ctr  = in_tdata[WORD_W-1:0];
  assign link_data[0].st   = make_init(in_tdata[WORD_W-1:0], key01_r, key23_r, key45_r,
                                       key67_r, nonce01_r, nonce2_r);

  for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
    cc20ks_round_cell #(
      .DIAG (1'(g % 2))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (link_valid[g]),
      .in_ready  (link_ready[g]),
      .in_data   (link_data[g]),
      .out_valid (link_valid[g+1]),
      .out_ready (link_ready[g+1]),
      .out_data  (link_data[g+1])
    );
  end

  state_t           init_out;
  logic [IDX_W-1:0] out_index;
  word_t            out_word;

  assign init_out = make_init(link_data[ROUNDS].ctr, key01_r, key23_r, key45_r,
                              key67_r, nonce01_r, nonce2_r);

  cc20ks_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (link_valid[ROUNDS]),
    .in_ready  (link_ready[ROUNDS]),
    .final_st  (link_data[ROUNDS].st),
    .init_st   (init_out),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_index (out_index),
    .out_word  (out_word),
    .out_last  (out_tlast)
  );

  assign out_tdata = {{(OUT_TDATA_W - WORD_W - IDX_W){1'b0}}, out_word, out_index};

endmodule

`default_nettype wire

### rtl/cc20ks_round_cell.sv
// One round cell of the chain: runs one column or diagonal round in four steps.
// Depends on cc20ks_pkg and the assertion macro header.
`default_nettype none
`include "chacha20_keystream_block_assert.svh"

module cc20ks_round_cell #(
  parameter bit DIAG = 1'b0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  cc20ks_pkg::cell_data_t in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cc20ks_pkg::cell_data_t out_data
);

  import cc20ks_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } cell_state_t;

  localparam logic [1:0] STEP_A16 = 2'd0;
  localparam logic [1:0] STEP_C12 = 2'd1;
  localparam logic [1:0] STEP_A8  = 2'd2;
  localparam logic [1:0] STEP_C7  = 2'd3;

  function automatic word_t rotl(word_t v, int n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic state_t round_step(state_t s, logic [1:0] step);
    state_t      r;
    logic [3:0]  ai;
    logic [3:0]  bi;
    logic [3:0]  ci;
    logic [3:0]  di;
    word_t       sum;
    r = s;
    for (int q = 0; q < 4; q++) begin
      ai = 4'(q);
      bi = 4'(4 + (DIAG ? ((q + 1) & 3) : q));
      ci = 4'(8 + (DIAG ? ((q + 2) & 3) : q));
      di = 4'(12 + (DIAG ? ((q + 3) & 3) : q));
      unique case (step)
        STEP_A16: begin
          sum   = r[ai] + r[bi];
          r[ai] = sum;
          r[di] = rotl(r[di] ^ sum, 16);
        end
        STEP_C12: begin
          sum   = r[ci] + r[di];
          r[ci] = sum;
          r[bi] = rotl(r[bi] ^ sum, 12);
        end
        STEP_A8: begin
          sum   = r[ai] + r[bi];
          r[ai] = sum;
          r[di] = rotl(r[di] ^ sum, 8);
        end
        STEP_C7: begin
          sum   = r[ci] + r[di];
          r[ci] = sum;
          r[bi] = rotl(r[bi] ^ sum, 7);
        end
        default: begin
          sum = '0;
        end
      endcase
    end
    return r;
  endfunction

  cell_state_t state_r;
  logic [1:0]  step_r;
  cell_data_t  data_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_HOLD);
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= STEP_A16;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_RUN;
            step_r  <= STEP_A16;
            data_r  <= in_data;
          end
        end
        S_RUN: begin
          data_r.st <= round_step(data_r.st, step_r);
          step_r    <= step_r + 2'd1;
          if (step_r == STEP_C7) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `CC20KS_ASSERT_NEXT(a_load_starts_run, in_valid && in_ready,
    state_r == S_RUN && step_r == STEP_A16, "cell load did not start a round")
  `CC20KS_ASSERT_NEXT(a_last_step_holds, state_r == S_RUN && step_r == STEP_C7,
    state_r == S_HOLD, "cell did not hold after the last step")
  `CC20KS_ASSERT_NEXT(a_hold_keeps_data, out_valid && !out_ready,
    out_valid && $stable(data_r), "cell data changed while stalled")
  `CC20KS_ASSERT_ALWAYS(a_run_not_ready, state_r != S_RUN || (!in_ready && !out_valid),
    "cell handshakes while running")

endmodule

`default_nettype wire

### rtl/cc20ks_emit.sv
// Output stage: adds the initial state to the final state and shifts out 16 words.
// Depends on cc20ks_pkg and the assertion macro header.
`default_nettype none
`include "chacha20_keystream_block_assert.svh"

module cc20ks_emit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cc20ks_pkg::state_t        final_st,
  input  cc20ks_pkg::state_t        init_st,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [cc20ks_pkg::IDX_W-1:0] out_index,
  output cc20ks_pkg::word_t         out_word,
  output logic                      out_last
);

  import cc20ks_pkg::*;

  logic             full_r;
  logic [IDX_W-1:0] idx_r;
  state_t           ks_r;
  state_t           ks_nxt;
  logic             out_fire;

  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      ks_nxt[i] = final_st[i] + init_st[i];
    end
  end

  assign out_valid = full_r;
  assign out_index = idx_r;
  assign out_word  = ks_r[0];
  assign out_last  = (idx_r == LAST_IDX);
  assign out_fire  = full_r && out_ready;
  assign in_ready  = !full_r || (out_ready && idx_r == LAST_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        full_r <= 1'b1;
        idx_r  <= '0;
        ks_r   <= ks_nxt;
      end else if (out_fire) begin
        ks_r <= {word_t'(0), ks_r[NUM_WORDS-1:1]};
        if (idx_r == LAST_IDX) begin
          full_r <= 1'b0;
          idx_r  <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  `CC20KS_ASSERT_ALWAYS(a_idle_index_zero, full_r || idx_r == '0,
    "word index not cleared while empty")
  `CC20KS_ASSERT_NEXT(a_index_advances, out_fire && idx_r != LAST_IDX,
    full_r && idx_r == $past(idx_r) + 1'b1, "word index did not advance")
  `CC20KS_ASSERT_NEXT(a_stall_holds, full_r && !out_ready,
    full_r && $stable(idx_r) && $stable(ks_r), "output changed while stalled")

endmodule

`default_nettype wire

### bench/chacha20_keystream_block_tb.sv
// Testbench for chacha20_keystream_block: drives block counters and key/nonce writes,
// predicts each 16-word keystream block and checks every output word in order.
// Depends on cc20ks_pkg and the block RTL.
`timescale 1ns / 1ps

module chacha20_keystream_block_tb;
  import cc20ks_pkg::*;

  localparam int ROUNDS       = ROUNDS_DEF;
  localparam int LATENCY      = 5 * ROUNDS + 1;
  localparam int HOLD_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 28;
  localparam int MAX_REPORTS  = 10;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct {
    logic [IDX_W-1:0] idx;
    word_t            word;
    logic             last;
  } ks_word_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [31:0] block_counter
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [3:0] word_index, [35:4] keystream_word
  logic                   out_tlast;

  chacha20_keystream_block #(.ROUNDS(ROUNDS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  word_t    key_w [8];
  word_t    nonce_w [3];
  word_t    ctr_queue [$];
  ks_word_t ks_expect [$];
  int       words_pending = 0;
  int       err_count = 0;
  int       cycle_count = 0;
  logic     in_took = 1'b0;
  logic     out_took = 1'b0;
  logic     tx_idle = 1'b0;
  logic     rx_idle = 1'b0;
  logic     hold_req = 1'b0;
  logic     hold_ack = 1'b0;
  int       tx_wait = 0;
  int       rx_wait = 0;
  int       rx_hold_cnt = 0;

  function automatic word_t rotl(input word_t v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [127:0] quarter_round(input word_t a, b, c, d);
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    return {a, b, c, d};
  endfunction

  function automatic state_t chacha_block(input word_t ctr);
    word_t  init_s [16];
    word_t  w [16];
    state_t ks;
    int     a, b, c, d;
    init_s[0] = SIGMA_0;
    init_s[1] = SIGMA_1;
    init_s[2] = SIGMA_2;
    init_s[3] = SIGMA_3;
    for (int i = 0; i < 8; i++) init_s[4 + i] = key_w[i];
    init_s[12] = ctr;
    for (int i = 0; i < 3; i++) init_s[13 + i] = nonce_w[i];
    w = init_s;
    for (int r = 0; r < ROUNDS; r++) begin
      for (int i = 0; i < 4; i++) begin
        a = i;
        if (r % 2 == 0) begin
          b = 4 + i; c = 8 + i; d = 12 + i;
        end else begin
          b = 4 + (i + 1) % 4; c = 8 + (i + 2) % 4; d = 12 + (i + 3) % 4;
        end
        {w[a], w[b], w[c], w[d]} = quarter_round(w[a], w[b], w[c], w[d]);
      end
    end
    for (int i = 0; i < NUM_WORDS; i++) ks[i] = w[i] + init_s[i];
    return ks;
  endfunction

  function automatic logic [63:0] rand_reg_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_ctr(input word_t c);
    ctr_queue.insert(ctr_queue.size(), c);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      REG_KEY_01:   {key_w[1], key_w[0]} = data;
      REG_KEY_23:   {key_w[3], key_w[2]} = data;
      REG_KEY_45:   {key_w[5], key_w[4]} = data;
      REG_KEY_67:   {key_w[7], key_w[6]} = data;
      REG_NONCE_01: {nonce_w[1], nonce_w[0]} = data;
      REG_NONCE_2:  nonce_w[2] = data[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (!(ctr_queue.size() == 0 && !in_tvalid && words_pending == 0));
  endtask

  // sender: hold the word until taken, then wait out the drawn gap
  always @(negedge clk) begin : tx_drive
    if (rst_n) begin
      if (in_took) tx_wait = tx_idle ? $urandom_range(0, 19) : 0;
      if (in_tvalid && !in_took) begin
      end else if (tx_wait > 0) begin
        tx_wait--;
        in_tvalid <= 1'b0;
      end else if (ctr_queue.size() > 0) begin
        in_tdata  <= ctr_queue.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall per word, or for a long stretch on request
  always @(negedge clk) begin : rx_drive
    if (rst_n) begin
      if (hold_req != hold_ack) begin
        hold_ack    = hold_req;
        rx_hold_cnt = HOLD_CYCLES;
      end
      if (out_took) rx_wait = rx_idle ? $urandom_range(0, 19) : 0;
      if (rx_hold_cnt > 0) begin
        rx_hold_cnt--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    ks_word_t exp_w;
    ks_word_t got_w;
    state_t   ks;
    int       pops;
    int       pushes;
    pops   = 0;
    pushes = 0;
    in_took  <= in_tvalid && in_tready;
    out_took <= out_tvalid && out_tready;
    if (out_tvalid && out_tready) begin
      got_w.idx  = out_tdata[3:0];
      got_w.word = out_tdata[35:4];
      got_w.last = out_tlast;
      if (ks_expect.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected word: idx %0d word %08h last %0b",
                   got_w.idx, got_w.word, got_w.last);
      end else begin
        exp_w = ks_expect.pop_front();
        pops  = 1;
        if (got_w.idx !== exp_w.idx || got_w.word !== exp_w.word ||
            got_w.last !== exp_w.last) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("word mismatch: expected idx %0d word %08h last %0b, got idx %0d word %08h last %0b",
                     exp_w.idx, exp_w.word, exp_w.last, got_w.idx, got_w.word, got_w.last);
        end
      end
    end
    if (in_tvalid && in_tready) begin
      ks = chacha_block(in_tdata);
      for (int i = 0; i < NUM_WORDS; i++) begin
        exp_w.idx  = i[IDX_W-1:0];
        exp_w.word = ks[i];
        exp_w.last = (exp_w.idx == LAST_IDX);
        ks_expect.insert(ks_expect.size(), exp_w);
      end
      pushes = NUM_WORDS;
    end
    words_pending <= words_pending + pushes - pops;
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    word_t base;
    int    style;
    word_t ctr;
    for (int i = 0; i < 8; i++) key_w[i] = '0;
    for (int i = 0; i < 3; i++) nonce_w[i] = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // writes to spare indexes must leave the all-zero key in place
    write_reg(REG_SPARE_6, '1);
    write_reg(REG_SPARE_7, '1);
    @(posedge clk);
    add_ctr(32'h0000_0000);
    add_ctr(32'h0000_0001);
    add_ctr(32'hFFFF_FFFF);
    add_ctr(32'h8000_0000);
    add_ctr(32'h7FFF_FFFF);
    wait_drained();

    // standard test vector key and nonce; upper bits of the third nonce word are dropped
    write_reg(REG_KEY_01,   {32'h0706_0504, 32'h0302_0100});
    write_reg(REG_KEY_23,   {32'h0f0e_0d0c, 32'h0b0a_0908});
    write_reg(REG_KEY_45,   {32'h1716_1514, 32'h1312_1110});
    write_reg(REG_KEY_67,   {32'h1f1e_1d1c, 32'h1b1a_1918});
    write_reg(REG_NONCE_01, {32'h4a00_0000, 32'h0900_0000});
    write_reg(REG_NONCE_2,  64'hFFFF_FFFF_0000_0000);
    @(posedge clk);
    rx_idle = 1'b1;
    add_ctr(32'h0000_0001);
    add_ctr(32'h0000_0000);
    add_ctr(32'hFFFF_FFFE);
    wait_drained();

    write_reg(REG_KEY_01,   '1);
    write_reg(REG_KEY_23,   '1);
    write_reg(REG_KEY_45,   '1);
    write_reg(REG_KEY_67,   '1);
    write_reg(REG_NONCE_01, '1);
    write_reg(REG_NONCE_2,  '1);
    @(posedge clk);
    tx_idle = 1'b1;
    add_ctr(32'h0000_0000);
    add_ctr(32'hFFFF_FFFF);
    add_ctr(32'hAAAA_AAAA);
    add_ctr(32'h5555_5555);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_reg(REG_KEY_01,   rand_reg_value());
      write_reg(REG_KEY_23,   rand_reg_value());
      write_reg(REG_KEY_45,   rand_reg_value());
      write_reg(REG_KEY_67,   rand_reg_value());
      write_reg(REG_NONCE_01, rand_reg_value());
      write_reg(REG_NONCE_2,  rand_reg_value());
      @(posedge clk);
      tx_idle = p[1];
      rx_idle = p[0];
      style = $urandom_range(0, 3);
      base  = $urandom;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case (style)
          0: ctr = $urandom;
          1: ctr = base + k;
          2: ctr = 32'hFFFF_FFF0 + k;
          default: ctr = ($urandom_range(0, 3) == 0) ? {32{$urandom_range(0, 1) == 1}}
                                                      : $urandom;
        endcase
        add_ctr(ctr);
      end
      wait_drained();
    end

    // stall the receiver while the sender keeps offering, so the block backs up
    @(posedge clk);
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_req = ~hold_req;
    for (int k = 0; k < PHASE_ITEMS; k++) add_ctr($urandom);
    wait_drained();

    repeat (LATENCY + 20) @(posedge clk);
    if (err_count == 0 && ks_expect.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### chacha20_keystream_block.f
+incdir+rtl
rtl/cc20ks_pkg.sv
rtl/cc20ks_round_cell.sv
rtl/cc20ks_emit.sv
rtl/chacha20_keystream_block.sv
bench/chacha20_keystream_block_tb.sv
